// ----- rtl/core/bar_pkg.sv -----
// Shared constants and types for the button auto-repeat unit.
// No dependencies; imported by button_auto_repeat_unit.
package bar_pkg;

   localparam int unsigned BUTTONS_PER_PLAYER = 6;
   localparam int unsigned NUM_PLAYERS        = 2;
   localparam int unsigned NUM_BUTTONS        = BUTTONS_PER_PLAYER * NUM_PLAYERS;
   localparam int unsigned MOUSE_WIDTH        = 3;
   localparam int unsigned MOUSE_SHIFT        = 4;
   localparam int unsigned HELD_FIRST_WIDTH   = 7;
   localparam int unsigned AGE_WIDTH          = 8;
   localparam int unsigned CSR_DATA_WIDTH     = 8;
   localparam int unsigned CSR_INDEX_WIDTH    = 2;

   typedef logic [AGE_WIDTH-1:0]   age_type;
   typedef logic [NUM_BUTTONS-1:0] button_vec_type;

   localparam age_type AGE_MAX          = 8'd255;
   localparam age_type DELAY_OFF        = 8'd255;
   localparam age_type DEFAULT_DELAY    = 8'd15;
   localparam age_type DEFAULT_INTERVAL = 8'd4;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_REPEAT_DELAY     = 2'd0,
      CSR_REPEAT_INTERVAL  = 2'd1,
      CSR_MOUSE_AS_BUTTONS = 2'd2
   } csr_index_type;

endpackage

// ----- rtl/core/button_auto_repeat_unit.sv -----
// Button auto-repeat unit: per-frame press and repeat pulse generation.
// Depends on bar_pkg (constants, age and register index types).
//
// Each req beat is one frame tick carrying two players' six-button held masks
// and three mouse buttons. The unit answers every frame with exactly one rsp
// beat: the held masks (player 0 widened to seven bits, mouse buttons ORed
// into bits 4 to 6 when mouse_as_buttons is set) and a pulse mask per player.
// A button pulses on its first held frame, again after repeat_delay frames,
// then every repeat_interval frames while held; releasing it clears its
// state. A delay or interval of 0 selects the default (15 and 4 frames); a
// delay of 255 stops new repeats from starting, while a button already
// repeating keeps going. Throughput is one frame per clock: a frame is
// captured in an input register, its twelve button counters update on the
// edge that loads the rsp register, and a new frame is taken every cycle
// the rsp side keeps up. rsp valid rises once the frame has moved from the
// input register into the rsp register, later if rsp stalls. The user must
// write registers through the csr port only while no frame is in flight;
// the unit does not enforce this. A write takes effect from the next frame.
module button_auto_repeat_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // frame input
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [bar_pkg::BUTTONS_PER_PLAYER-1:0] req_buttons_first,
   input  logic [bar_pkg::BUTTONS_PER_PLAYER-1:0] req_buttons_second,
   input  logic [bar_pkg::MOUSE_WIDTH-1:0]        req_mouse_keys,
   // result output
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [bar_pkg::HELD_FIRST_WIDTH-1:0]   rsp_held_first,
   output logic [bar_pkg::BUTTONS_PER_PLAYER-1:0] rsp_held_second,
   output logic [bar_pkg::BUTTONS_PER_PLAYER-1:0] rsp_pulse_first,
   output logic [bar_pkg::BUTTONS_PER_PLAYER-1:0] rsp_pulse_second,
   // register write port
   input  logic                                  csr_write_enable,
   input  logic [bar_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [bar_pkg::CSR_DATA_WIDTH-1:0]     csr_write_data
);
   import bar_pkg::*;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   age_type repeat_delay_ff,     repeat_delay_in;
   age_type repeat_interval_ff,  repeat_interval_in;
   logic    mouse_as_buttons_ff, mouse_as_buttons_in;

   always_comb begin
      repeat_delay_in     = repeat_delay_ff;
      repeat_interval_in  = repeat_interval_ff;
      mouse_as_buttons_in = mouse_as_buttons_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_REPEAT_DELAY:     repeat_delay_in     = csr_write_data;
            CSR_REPEAT_INTERVAL:  repeat_interval_in  = csr_write_data;
            CSR_MOUSE_AS_BUTTONS: mouse_as_buttons_in = csr_write_data[0];
            default: ;  // unmapped index: write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         repeat_delay_ff     <= '0;
         repeat_interval_ff  <= '0;
         mouse_as_buttons_ff <= 1'b0;
      end else begin
         repeat_delay_ff     <= repeat_delay_in;
         repeat_interval_ff  <= repeat_interval_in;
         mouse_as_buttons_ff <= mouse_as_buttons_in;
      end
   end

   // ---------------------------------------------------------------------
   // Handshake: input stage -> rsp register
   // ---------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_load;   // rsp register free this cycle
   logic s1_advance; // frame in the input stage moves to rsp (state commits)
   logic req_take;

   assign rsp_load   = !rsp_valid_ff || rsp_ready;
   assign s1_advance = s1_valid_ff && rsp_load;
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_take   = req_valid && req_ready;

   assign s1_valid_in  = req_take ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input stage payload (no reset needed)
   logic [BUTTONS_PER_PLAYER-1:0] s1_first_ff, s1_second_ff;
   logic [MOUSE_WIDTH-1:0]        s1_mouse_ff;

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_first_ff  <= req_buttons_first;
         s1_second_ff <= req_buttons_second;
         s1_mouse_ff  <= req_mouse_keys;
      end
   end

   // ---------------------------------------------------------------------
   // Per-button state and pulse logic
   // ---------------------------------------------------------------------
   age_type        age_ff [NUM_BUTTONS];
   age_type        age_in [NUM_BUTTONS];
   button_vec_type held_ff, held_in;
   button_vec_type repeating_ff, repeating_in;

   logic [HELD_FIRST_WIDTH-1:0] held0_merged;
   button_vec_type              all_held;
   button_vec_type              pulses;
   button_vec_type              age_nonzero; // for checks only
   age_type                     delay_eff;
   age_type                     interval_eff;

   always_comb begin
      held0_merged = {1'b0, s1_first_ff};
      if (mouse_as_buttons_ff) begin
         held0_merged = held0_merged | {s1_mouse_ff, {MOUSE_SHIFT{1'b0}}};
      end
      all_held = {s1_second_ff, held0_merged[BUTTONS_PER_PLAYER-1:0]};

      delay_eff    = (repeat_delay_ff == '0)    ? DEFAULT_DELAY    : repeat_delay_ff;
      interval_eff = (repeat_interval_ff == '0) ? DEFAULT_INTERVAL : repeat_interval_ff;
   end

   always_comb begin
      age_type age_next;
      held_in      = held_ff;
      repeating_in = repeating_ff;
      pulses       = '0;
      for (int k = 0; k < NUM_BUTTONS; k++) begin
         age_in[k]      = age_ff[k];
         age_nonzero[k] = (age_ff[k] != '0);
         age_next = (age_ff[k] == AGE_MAX) ? AGE_MAX : age_ff[k] + 8'd1;
         if (all_held[k]) begin
            if (!held_ff[k]) begin
               // fresh press
               held_in[k] = 1'b1;
               age_in[k]  = '0;
               pulses[k]  = 1'b1;
            end else if (delay_eff != DELAY_OFF && !repeating_ff[k]
                         && age_next >= delay_eff) begin
               // first repeat
               age_in[k]       = '0;
               repeating_in[k] = 1'b1;
               pulses[k]       = 1'b1;
            end else if (repeating_ff[k] && age_next >= interval_eff) begin
               age_in[k] = '0;
               pulses[k] = 1'b1;
            end else begin
               age_in[k] = age_next;
            end
         end else begin
            held_in[k]      = 1'b0;
            repeating_in[k] = 1'b0;
            age_in[k]       = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         repeating_ff <= '0;
         for (int k = 0; k < NUM_BUTTONS; k++) begin
            age_ff[k] <= '0;
         end
      end else if (s1_advance) begin
         held_ff      <= held_in;
         repeating_ff <= repeating_in;
         for (int k = 0; k < NUM_BUTTONS; k++) begin
            age_ff[k] <= age_in[k];
         end
      end
   end

   // ---------------------------------------------------------------------
   // rsp register
   // ---------------------------------------------------------------------
   logic [HELD_FIRST_WIDTH-1:0]   rsp_held_first_ff;
   logic [BUTTONS_PER_PLAYER-1:0] rsp_held_second_ff;
   logic [BUTTONS_PER_PLAYER-1:0] rsp_pulse_first_ff;
   logic [BUTTONS_PER_PLAYER-1:0] rsp_pulse_second_ff;

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_held_first_ff   <= held0_merged;
         rsp_held_second_ff  <= s1_second_ff;
         rsp_pulse_first_ff  <= pulses[BUTTONS_PER_PLAYER-1:0];
         rsp_pulse_second_ff <= pulses[NUM_BUTTONS-1:BUTTONS_PER_PLAYER];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_held_first   = rsp_held_first_ff;
   assign rsp_held_second  = rsp_held_second_ff;
   assign rsp_pulse_first  = rsp_pulse_first_ff;
   assign rsp_pulse_second = rsp_pulse_second_ff;

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   // a button can only be repeating while it is held
   a_repeat_needs_held: assert property (@(posedge clock) disable iff (reset)
      (repeating_ff & ~held_ff) == '0)
      else $error("repeating flag set on a released button");

   // released buttons keep a zero age
   a_release_clears_age: assert property (@(posedge clock) disable iff (reset)
      (age_nonzero & ~held_ff) == '0)
      else $error("released button has nonzero age");

   // pulses only on buttons shown as held
   a_pulse_needs_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         ((rsp_pulse_first_ff & ~rsp_held_first_ff[BUTTONS_PER_PLAYER-1:0]) == '0)
         && ((rsp_pulse_second_ff & ~rsp_held_second_ff) == '0))
      else $error("pulse on a button that is not held");

   // every fresh press pulses
   a_press_pulses: assert property (@(posedge clock) disable iff (reset)
      s1_advance |-> ((all_held & ~held_ff & ~pulses) == '0))
      else $error("new press without pulse");

endmodule

// ----- bench/button_auto_repeat_checker.sv -----
// Scoreboard for button_auto_repeat_unit: tracks register writes, predicts each frame.
// Depends on bar_pkg; instantiated beside the unit by tb_button_auto_repeat_unit.
`timescale 1ns / 100ps
module button_auto_repeat_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_ready,
   input  logic [bar_pkg::BUTTONS_PER_PLAYER-1:0] req_buttons_first,
   input  logic [bar_pkg::BUTTONS_PER_PLAYER-1:0] req_buttons_second,
   input  logic [bar_pkg::MOUSE_WIDTH-1:0]        req_mouse_keys,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic [bar_pkg::HELD_FIRST_WIDTH-1:0]   rsp_held_first,
   input  logic [bar_pkg::BUTTONS_PER_PLAYER-1:0] rsp_held_second,
   input  logic [bar_pkg::BUTTONS_PER_PLAYER-1:0] rsp_pulse_first,
   input  logic [bar_pkg::BUTTONS_PER_PLAYER-1:0] rsp_pulse_second,
   input  logic                                   csr_write_enable,
   input  logic [bar_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [bar_pkg::CSR_DATA_WIDTH-1:0]     csr_write_data,
   output int                                     fail_count,
   output int                                     pending_beats,
   output int                                     frames_checked,
   output int                                     pulse_beats
);
   import bar_pkg::*;

   typedef struct packed {
      logic [HELD_FIRST_WIDTH-1:0]   held_first;
      logic [BUTTONS_PER_PLAYER-1:0] held_second;
      logic [BUTTONS_PER_PLAYER-1:0] pulse_first;
      logic [BUTTONS_PER_PLAYER-1:0] pulse_second;
   } frame_result_type;

   age_type          button_age [NUM_BUTTONS];
   button_vec_type   was_held;
   button_vec_type   in_repeat;
   age_type          delay_q;
   age_type          interval_q;
   logic             mouse_merge_q;
   frame_result_type expected_frames [$];

   initial begin
      fail_count     = 0;
      pending_beats  = 0;
      frames_checked = 0;
      pulse_beats    = 0;
   end

   // one frame tick of the auto-repeat logic
   task automatic advance_frame(input  logic [BUTTONS_PER_PLAYER-1:0] b_first,
                                input  logic [BUTTONS_PER_PLAYER-1:0] b_second,
                                input  logic [MOUSE_WIDTH-1:0]        mouse,
                                output frame_result_type              res);
      logic [HELD_FIRST_WIDTH-1:0] merged;
      button_vec_type              all_held;
      button_vec_type              pulses;
      age_type                     delay_eff;
      age_type                     interval_eff;
      age_type                     age;
      int                          k;
      merged = {1'b0, b_first};
      if (mouse_merge_q)
         merged = merged | {mouse, 4'b0000};
      delay_eff    = (delay_q == 8'd0) ? DEFAULT_DELAY : delay_q;
      interval_eff = (interval_q == 8'd0) ? DEFAULT_INTERVAL : interval_q;
      all_held     = {b_second, merged[BUTTONS_PER_PLAYER-1:0]};
      pulses       = '0;
      for (k = 0; k < NUM_BUTTONS; k++) begin
         if (all_held[k]) begin
            if (!was_held[k]) begin
               was_held[k]   = 1'b1;
               button_age[k] = '0;
               pulses[k]     = 1'b1;
            end else begin
               age = button_age[k];
               if (age < AGE_MAX)
                  age = age + 8'd1;
               if (delay_eff != DELAY_OFF && !in_repeat[k] && age >= delay_eff) begin
                  age          = '0;
                  in_repeat[k] = 1'b1;
                  pulses[k]    = 1'b1;
               end else if (in_repeat[k] && age >= interval_eff) begin
                  age       = '0;
                  pulses[k] = 1'b1;
               end
               button_age[k] = age;
            end
         end else begin
            was_held[k]   = 1'b0;
            in_repeat[k]  = 1'b0;
            button_age[k] = '0;
         end
      end
      res.held_first   = merged;
      res.held_second  = b_second;
      res.pulse_first  = pulses[BUTTONS_PER_PLAYER-1:0];
      res.pulse_second = pulses[NUM_BUTTONS-1:BUTTONS_PER_PLAYER];
   endtask

   always @(posedge clock) begin
      frame_result_type want;
      frame_result_type got;
      int               k;
      if (reset) begin
         for (k = 0; k < NUM_BUTTONS; k++)
            button_age[k] = '0;
         was_held      = '0;
         in_repeat     = '0;
         delay_q       = '0;
         interval_q    = '0;
         mouse_merge_q = 1'b0;
         expected_frames.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_REPEAT_DELAY:     delay_q       = csr_write_data;
               CSR_REPEAT_INTERVAL:  interval_q    = csr_write_data;
               CSR_MOUSE_AS_BUTTONS: mouse_merge_q = csr_write_data[0];
               default: ;
            endcase
         end
         // compare before predicting so a stray rsp beat is never masked
         if (rsp_valid && rsp_ready) begin
            if (expected_frames.size() == 0) begin
               $error("rsp beat with no frame outstanding");
               fail_count++;
            end else begin
               want = expected_frames.pop_front();
               got  = '{rsp_held_first, rsp_held_second, rsp_pulse_first, rsp_pulse_second};
               if (got.held_first !== want.held_first) begin
                  $error("held_first expected %0h actual %0h", want.held_first, got.held_first);
                  fail_count++;
               end
               if (got.held_second !== want.held_second) begin
                  $error("held_second expected %0h actual %0h",
                         want.held_second, got.held_second);
                  fail_count++;
               end
               if (got.pulse_first !== want.pulse_first) begin
                  $error("pulse_first expected %0h actual %0h",
                         want.pulse_first, got.pulse_first);
                  fail_count++;
               end
               if (got.pulse_second !== want.pulse_second) begin
                  $error("pulse_second expected %0h actual %0h",
                         want.pulse_second, got.pulse_second);
                  fail_count++;
               end
               frames_checked++;
               if (want.pulse_first != '0 || want.pulse_second != '0)
                  pulse_beats++;
            end
         end
         if (req_valid && req_ready) begin
            advance_frame(req_buttons_first, req_buttons_second, req_mouse_keys, want);
            expected_frames.push_back(want);
         end
      end
      pending_beats = expected_frames.size();
   end

endmodule

// ----- bench/tb_button_auto_repeat_unit.sv -----
// Top of the button auto-repeat bench: clock, reset, frame and register stimulus.
// Depends on bar_pkg, button_auto_repeat_unit and button_auto_repeat_checker.
`timescale 1ns / 100ps
module tb_button_auto_repeat_unit;
   import bar_pkg::*;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic [BUTTONS_PER_PLAYER-1:0]   req_buttons_first;
   logic [BUTTONS_PER_PLAYER-1:0]   req_buttons_second;
   logic [MOUSE_WIDTH-1:0]          req_mouse_keys;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [HELD_FIRST_WIDTH-1:0]     rsp_held_first;
   logic [BUTTONS_PER_PLAYER-1:0]   rsp_held_second;
   logic [BUTTONS_PER_PLAYER-1:0]   rsp_pulse_first;
   logic [BUTTONS_PER_PLAYER-1:0]   rsp_pulse_second;
   logic                            csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0]      csr_index;
   logic [CSR_DATA_WIDTH-1:0]       csr_write_data;

   int fail_count;
   int pending_beats;
   int frames_checked;
   int pulse_beats;

   // no idling on either side while this is set
   logic steady = 1'b0;

   // sticky held masks: buttons stay down for long runs so repeats get exercised
   logic [BUTTONS_PER_PLAYER-1:0] hold_first;
   logic [BUTTONS_PER_PLAYER-1:0] hold_second;
   logic [MOUSE_WIDTH-1:0]        hold_mouse;

   int frames_sent;
   int settings_used;

   always #10 clock = ~clock;

   button_auto_repeat_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_buttons_first  (req_buttons_first),
      .req_buttons_second (req_buttons_second),
      .req_mouse_keys     (req_mouse_keys),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_held_first     (rsp_held_first),
      .rsp_held_second    (rsp_held_second),
      .rsp_pulse_first    (rsp_pulse_first),
      .rsp_pulse_second   (rsp_pulse_second),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   button_auto_repeat_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_buttons_first  (req_buttons_first),
      .req_buttons_second (req_buttons_second),
      .req_mouse_keys     (req_mouse_keys),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_held_first     (rsp_held_first),
      .rsp_held_second    (rsp_held_second),
      .rsp_pulse_first    (rsp_pulse_first),
      .rsp_pulse_second   (rsp_pulse_second),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .fail_count         (fail_count),
      .pending_beats      (pending_beats),
      .frames_checked     (frames_checked),
      .pulse_beats        (pulse_beats)
   );

   // rsp side stalls about 11% of cycles, except in the steady stretch
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 11);
   end

   // Drive one frame beat. Entered at a rising edge; returns at the edge that
   // accepts the beat, with req_valid still high so back-to-back beats never
   // see valid dropped and raised in the same step.
   task automatic send_frame(input logic [BUTTONS_PER_PLAYER-1:0] b_first,
                             input logic [BUTTONS_PER_PLAYER-1:0] b_second,
                             input logic [MOUSE_WIDTH-1:0]        mouse);
      while (!steady && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_buttons_first  <= b_first;
      req_buttons_second <= b_second;
      req_mouse_keys     <= mouse;
      // ready is stable mid-cycle; high at the falling edge means taken at the next rise
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      frames_sent++;
   endtask

   // drain: every frame answered, then slack for the pipeline
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_beats != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(input age_type delay, input age_type interval,
                            input logic mouse_merge);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_REPEAT_DELAY;
      csr_write_data   <= delay;
      @(posedge clock);
      csr_index        <= CSR_REPEAT_INTERVAL;
      csr_write_data   <= interval;
      @(posedge clock);
      csr_index        <= CSR_MOUSE_AS_BUTTONS;
      csr_write_data   <= {7'd0, mouse_merge};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   // flip each held bit with probability 1/toggle_div
   task automatic step_masks(input int unsigned toggle_div);
      int k;
      for (k = 0; k < BUTTONS_PER_PLAYER; k++) begin
         if ($urandom_range(toggle_div - 1) == 0) hold_first[k]  = ~hold_first[k];
         if ($urandom_range(toggle_div - 1) == 0) hold_second[k] = ~hold_second[k];
      end
      for (k = 0; k < MOUSE_WIDTH; k++)
         if ($urandom_range(toggle_div - 1) == 0) hold_mouse[k] = ~hold_mouse[k];
   endtask

   // mostly sticky held patterns; short-hold phases also mix in about one
   // frame in twenty of pure noise, long-hold phases none so ages can saturate
   task automatic run_frames(input int count, input int unsigned toggle_div);
      int n;
      for (n = 0; n < count; n++) begin
         if (toggle_div < 100 && $urandom_range(19) == 0) begin
            send_frame(6'($urandom_range(63)), 6'($urandom_range(63)),
                       3'($urandom_range(7)));
         end else begin
            step_masks(toggle_div);
            send_frame(hold_first, hold_second, hold_mouse);
         end
      end
   endtask

   initial begin
      int n;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_buttons_first  = '0;
      req_buttons_second = '0;
      req_mouse_keys     = '0;
      csr_write_enable   = 1'b0;
      csr_index          = CSR_REPEAT_DELAY;
      csr_write_data     = '0;
      hold_first         = '0;
      hold_second        = '0;
      hold_mouse         = '0;
      frames_sent        = 0;
      settings_used      = 1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset defaults (delay 15, interval 4, no mouse merge).
      // Everything pressed on the very first frame after reset, then held long
      // enough for the first repeat and a couple of interval repeats.
      for (n = 0; n < 24; n++)
         send_frame(6'h3F, 6'h3F, 3'h7);
      // release clears all state; then alternating single-frame patterns
      send_frame(6'h00, 6'h00, 3'h0);
      send_frame(6'h15, 6'h2A, 3'h5);
      send_frame(6'h2A, 6'h15, 3'h2);

      // mouse merge: bit 6 of player 0 is held-only, bits 4..5 OR with buttons
      configure(8'd0, 8'd0, 1'b1);
      send_frame(6'h00, 6'h00, 3'h7);
      send_frame(6'h30, 6'h00, 3'h1);
      send_frame(6'h00, 6'h00, 3'h0);

      // Random phases. State carries across them on purpose: buttons left
      // repeating at fast settings keep repeating once delay turns repeat off.
      configure(8'd0, 8'd0, 1'b0);
      run_frames(200, 12);
      configure(8'd1, 8'd1, 1'b1);
      run_frames(150, 25);
      // repeat off, slowest interval, long holds: ages run into saturation
      configure(8'd255, 8'd255, 1'b1);
      run_frames(400, 700);
      // longest usable delay, no idling on either side for the whole phase
      configure(8'd254, 8'd255, 1'b0);
      steady <= 1'b1;
      run_frames(300, 700);
      steady <= 1'b0;
      for (n = 0; n < 3; n++) begin
         configure(age_type'($urandom_range(1, 30)), age_type'($urandom_range(1, 12)),
                   1'($urandom_range(1)));
         run_frames(80, 10);
      end

      wait_drained();
      repeat (8) @(posedge clock);
      $display("Ran %0d frames across %0d register settings; %0d frames checked, %0d with pulses.",
               frames_sent, settings_used, frames_checked, pulse_beats);
      if (fail_count == 0) begin
         $display("tb_button_auto_repeat_unit OK");
      end else begin
         $display("tb_button_auto_repeat_unit NOT OK");
      end
      $finish;
   end

   // watchdog: a correct run needs well under a tenth of this
   initial begin
      #2000000;
      $display("tb_button_auto_repeat_unit NOT OK");
      $finish;
   end

endmodule
